// File: sv/sts_pkg.sv
`timescale 1ns / 1ps

package sts_pkg;

    localparam int KEY_W   = 32;
    localparam int OP_W    = 2;
    localparam int IDX_W   = 10;
    localparam int BOUND_W = 11;
    localparam int POS_W   = 11;

    localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
    localparam logic [OP_W-1:0] OP_EXACT = 2'd1;
    localparam logic [OP_W-1:0] OP_LOWER = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_FIRST,
        S_PROBE,
        S_DONE
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic first;
        logic probe;
    } t_dp_cmd;

    // Status from the datapath back to the controller.
    typedef struct packed {
        logic in_search;
        logic range_ok;
        logic probe_stop;
    } t_dp_stat;

endpackage

// File: sv/sts_ctrl.sv
`timescale 1ns / 1ps

module sts_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  sts_pkg::t_dp_stat i_stat,
    output logic              busy,
    output logic              o_valid,
    output sts_pkg::t_dp_cmd  o_cmd
);

    sts_pkg::t_state r_state;
    sts_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sts_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            sts_pkg::S_IDLE: begin
                if (start) begin
                    n_state = i_stat.in_search ? sts_pkg::S_FIRST : sts_pkg::S_DONE;
                end
            end
            sts_pkg::S_FIRST: begin
                n_state = i_stat.range_ok ? sts_pkg::S_PROBE : sts_pkg::S_DONE;
            end
            sts_pkg::S_PROBE: begin
                if (i_stat.probe_stop) begin
                    n_state = sts_pkg::S_DONE;
                end
            end
            sts_pkg::S_DONE: begin
                n_state = sts_pkg::S_IDLE;
            end
            default: begin
                n_state = sts_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        busy        = 1'b1;
        o_valid     = 1'b0;
        o_cmd.load  = 1'b0;
        o_cmd.first = 1'b0;
        o_cmd.probe = 1'b0;
        case (r_state)
            sts_pkg::S_IDLE: begin
                // No item is taken while reset is held.
                busy       = !i_rst_n;
                o_cmd.load = start && i_rst_n;
            end
            sts_pkg::S_FIRST: begin
                o_cmd.first = 1'b1;
            end
            sts_pkg::S_PROBE: begin
                o_cmd.probe = 1'b1;
            end
            sts_pkg::S_DONE: begin
                o_valid = 1'b1;
            end
            default: begin
                busy = 1'b1;
            end
        endcase
    end

endmodule

// File: sv/sts_datapath.sv
`timescale 1ns / 1ps

module sts_datapath #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic                                    i_clk,
    input  sts_pkg::t_dp_cmd                        i_cmd,
    input  logic [sts_pkg::OP_W-1:0]                i_op,
    input  logic [sts_pkg::IDX_W-1:0]               i_entry_index,
    input  logic signed [sts_pkg::KEY_W-1:0]        i_key,
    input  logic [sts_pkg::BOUND_W-1:0]             i_range_low,
    input  logic [sts_pkg::BOUND_W-1:0]             i_range_high,
    output sts_pkg::t_dp_stat                       o_stat,
    output logic                                    o_found,
    output logic [sts_pkg::POS_W-1:0]               o_position
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int BW = $clog2(TABLE_DEPTH + 1);
    localparam int CW = (BW > sts_pkg::BOUND_W) ? BW : sts_pkg::BOUND_W;
    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

    logic signed [sts_pkg::KEY_W-1:0] mem [TABLE_DEPTH];

    logic [sts_pkg::OP_W-1:0]         r_op;
    logic signed [sts_pkg::KEY_W-1:0] r_key;
    logic signed [sts_pkg::KEY_W-1:0] r_rd;
    logic [CW-1:0]                    r_lo;
    logic [CW-1:0]                    r_hi;
    logic [CW-1:0]                    r_mid;
    logic                             r_found;
    logic [sts_pkg::POS_W-1:0]        r_pos;

    logic [CW-1:0] lo_ext, hi_ext, lo_in, hi_in, idx_ext;
    logic [CW-1:0] first_mid, lo_a, mid_a, mid_b;
    logic [CW-1:0] next_lo, next_hi, next_mid, rd_ptr;
    logic          go_a, go_b, go, key_gt, key_eq, hit, is_exact, is_lower;
    logic          wr_en, rd_en;

    always_comb begin
        lo_ext  = CW'(i_range_low);
        hi_ext  = CW'(i_range_high);
        lo_in   = (lo_ext > DEPTH_C) ? DEPTH_C : lo_ext;
        hi_in   = (hi_ext > DEPTH_C) ? DEPTH_C : hi_ext;
        idx_ext = CW'(i_entry_index);
        wr_en   = i_cmd.load && (i_op == sts_pkg::OP_LOAD) && (idx_ext < DEPTH_C);

        is_exact  = (r_op == sts_pkg::OP_EXACT);
        is_lower  = (r_op == sts_pkg::OP_LOWER);
        first_mid = r_lo + ((r_hi - r_lo) >> 1);

        key_gt = r_key > r_rd;
        key_eq = r_key == r_rd;
        hit    = is_exact && key_eq;

        // Both possible next probes are formed ahead of the compare; the
        // compare then only selects one.
        lo_a  = r_mid + CW'(1);
        mid_a = lo_a + ((r_hi - lo_a) >> 1);
        go_a  = lo_a < r_hi;
        mid_b = r_lo + ((r_mid - r_lo) >> 1);
        go_b  = r_lo < r_mid;

        next_lo  = key_gt ? lo_a : r_lo;
        next_hi  = key_gt ? r_hi : r_mid;
        next_mid = key_gt ? mid_a : mid_b;
        go       = key_gt ? go_a : go_b;

        o_stat.in_search  = (i_op == sts_pkg::OP_EXACT) || (i_op == sts_pkg::OP_LOWER);
        o_stat.range_ok   = r_lo < r_hi;
        o_stat.probe_stop = hit || !go;

        rd_en  = (i_cmd.first && o_stat.range_ok) || (i_cmd.probe && !o_stat.probe_stop);
        rd_ptr = i_cmd.first ? first_mid : next_mid;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[idx_ext[AW-1:0]] <= i_key;
        end
        if (rd_en) begin
            r_rd <= mem[rd_ptr[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op    <= i_op;
            r_key   <= i_key;
            r_lo    <= lo_in;
            r_hi    <= hi_in;
            r_found <= 1'b0;
            r_pos   <= '0;
        end
        if (i_cmd.first) begin
            r_mid <= first_mid;
            // An empty range answers the saturated low bound for lower bound.
            if (!o_stat.range_ok && is_lower) begin
                r_pos <= r_lo[sts_pkg::POS_W-1:0];
            end
        end
        if (i_cmd.probe) begin
            r_lo  <= next_lo;
            r_hi  <= next_hi;
            r_mid <= next_mid;
            if (hit) begin
                r_found <= 1'b1;
                r_pos   <= r_mid[sts_pkg::POS_W-1:0];
            end else if (!go && is_lower) begin
                r_pos <= next_lo[sts_pkg::POS_W-1:0];
            end
        end
    end

    assign o_found    = r_found;
    assign o_position = r_pos;

endmodule

// File: sv/sorted_table_search_core.sv
`timescale 1ns / 1ps
// Load and unused-op items: result strobe in the cycle after accept.
// Searches: a first read, then n probes, then the result strobe, where n is the
// number of probes (at most clog2(range)+1, 11 for a 1024-entry range); the table's
// single registered read port gives one probe per cycle. The receiver cannot stall.
// Reset (i_rst_n low at a clock edge) returns the controller to idle with busy held high;
// table contents are not cleared and read as undefined until written.

module sorted_table_search_core #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [sts_pkg::OP_W-1:0]          i_op,
    input  logic [sts_pkg::IDX_W-1:0]         i_entry_index,
    input  logic signed [sts_pkg::KEY_W-1:0]  i_key,
    input  logic [sts_pkg::BOUND_W-1:0]       i_range_low,
    input  logic [sts_pkg::BOUND_W-1:0]       i_range_high,
    output logic                              o_valid,
    output logic                              o_found,
    output logic [sts_pkg::POS_W-1:0]         o_position
);

    sts_pkg::t_dp_cmd  cmd;
    sts_pkg::t_dp_stat stat;

    sts_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_stat  (stat),
        .busy    (busy),
        .o_valid (o_valid),
        .o_cmd   (cmd)
    );

    sts_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_cmd         (cmd),
        .i_op          (i_op),
        .i_entry_index (i_entry_index),
        .i_key         (i_key),
        .i_range_low   (i_range_low),
        .i_range_high  (i_range_high),
        .o_stat        (stat),
        .o_found       (o_found),
        .o_position    (o_position)
    );

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("accepted item did not raise busy");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !busy && !o_valid)
        else $error("result strobe not followed by idle");

    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (32'(o_position) <= 32'(TABLE_DEPTH)))
        else $error("result position beyond table depth");

    a_found_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_found |-> (32'(o_position) < 32'(TABLE_DEPTH)))
        else $error("match reported outside the table");

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;

    import sts_pkg::*;

    localparam int DEPTH = 1024;
    localparam int ITEM_TARGET = 1350;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int TAIL_CYCLES = 30;
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic               found;
        logic [POS_W-1:0]   position;
    } answer_t;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [IDX_W-1:0]   idx;
        logic [KEY_W-1:0]   key;
        logic [BOUND_W-1:0] lo;
        logic [BOUND_W-1:0] hi;
        logic               fixed;
        logic               found;
        logic [POS_W-1:0]   position;
    } query_row_t;

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       start;
    logic                       busy;
    logic [OP_W-1:0]            i_op;
    logic [IDX_W-1:0]           i_entry_index;
    logic signed [KEY_W-1:0]    i_key;
    logic [BOUND_W-1:0]         i_range_low;
    logic [BOUND_W-1:0]         i_range_high;
    logic                       o_valid;
    logic                       o_found;
    logic [POS_W-1:0]           o_position;

    // Typed-in answer for the item on the ports, used instead of the predictor.
    logic                       row_fixed;
    answer_t                    row_answer;

    logic signed [KEY_W-1:0]    shadow_keys [DEPTH];
    bit                         loaded [DEPTH];
    answer_t                    pending_answers [$];
    int                         mismatch_count;
    int                         items_sent;
    int                         burst_left;
    int                         idle_cycles;

    sorted_table_search_core #(
        .TABLE_DEPTH(DEPTH)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_op          (i_op),
        .i_entry_index (i_entry_index),
        .i_key         (i_key),
        .i_range_low   (i_range_low),
        .i_range_high  (i_range_high),
        .o_valid       (o_valid),
        .o_found       (o_found),
        .o_position    (o_position)
    );

    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        $display("%0t ns: mismatch: %s", $time, msg);
    endtask

    // Applies one item to the shadow table and works out its answer.
    function automatic answer_t predict_answer(
        input logic [OP_W-1:0]          op,
        input logic [IDX_W-1:0]         idx,
        input logic signed [KEY_W-1:0]  key,
        input logic [BOUND_W-1:0]       lo_in,
        input logic [BOUND_W-1:0]       hi_in
    );
        answer_t a;
        int      lo;
        int      hi;
        int      mid;
        a = '0;
        lo = (lo_in > DEPTH) ? DEPTH : int'(lo_in);
        hi = (hi_in > DEPTH) ? DEPTH : int'(hi_in);
        case (op)
            OP_LOAD: begin
                if (idx < DEPTH) begin
                    shadow_keys[idx] = key;
                end
            end
            OP_EXACT: begin
                while (lo < hi && !a.found) begin
                    mid = lo + (hi - lo) / 2;
                    if (key > shadow_keys[mid]) begin
                        lo = mid + 1;
                    end else if (key < shadow_keys[mid]) begin
                        hi = mid;
                    end else begin
                        a.found = 1'b1;
                        a.position = POS_W'(mid);
                    end
                end
            end
            OP_LOWER: begin
                while (lo < hi) begin
                    mid = lo + (hi - lo) / 2;
                    if (shadow_keys[mid] < key) begin
                        lo = mid + 1;
                    end else begin
                        hi = mid;
                    end
                end
                a.position = POS_W'(lo);
            end
            default: begin
            end
        endcase
        return a;
    endfunction

    // True when every entry a search over the range could probe has been loaded.
    function automatic bit range_loaded(input int lo_in, input int hi_in);
        int lo;
        int hi;
        lo = (lo_in > DEPTH) ? DEPTH : lo_in;
        hi = (hi_in > DEPTH) ? DEPTH : hi_in;
        for (int n = lo; n < hi; n++) begin
            if (!loaded[n]) begin
                return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    task automatic send_item(
        input logic [OP_W-1:0]          op,
        input logic [IDX_W-1:0]         idx,
        input logic signed [KEY_W-1:0]  key,
        input logic [BOUND_W-1:0]       lo,
        input logic [BOUND_W-1:0]       hi,
        input logic                     fixed,
        input answer_t                  answer
    );
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            burst_left = $urandom_range(1, 24);
            if (gap > 0) begin
                @(negedge i_clk);
                start = 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
        burst_left--;
        @(negedge i_clk);
        i_op = op;
        i_entry_index = idx;
        i_key = key;
        i_range_low = lo;
        i_range_high = hi;
        row_fixed = fixed;
        row_answer = answer;
        start = 1'b1;
        if (op == OP_LOAD) begin
            loaded[idx] = 1'b1;
        end
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        items_sent++;
    endtask

    task automatic wait_for_results;
        @(negedge i_clk);
        start = 1'b0;
        while (pending_answers.size() != 0) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin : result_check
        answer_t got;
        answer_t want;
        if (i_rst_n) begin
            if (o_valid) begin
                got = '{found: o_found, position: o_position};
                if (pending_answers.size() == 0) begin
                    report_mismatch($sformatf("unexpected result found=%0d position=%0d",
                                              got.found, got.position));
                end else begin
                    want = pending_answers.pop_front();
                    if (got.found !== want.found) begin
                        report_mismatch($sformatf("found %0d, expected %0d",
                                                  got.found, want.found));
                    end
                    if (got.position !== want.position) begin
                        report_mismatch($sformatf("position %0d, expected %0d",
                                                  got.position, want.position));
                    end
                end
            end
            if (start && !busy) begin
                want = predict_answer(i_op, i_entry_index, i_key, i_range_low, i_range_high);
                if (row_fixed) begin
                    want = row_answer;
                end
                pending_answers.push_back(want);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin : stimulus
        query_row_t              directed_rows [25];
        logic signed [KEY_W-1:0] seg_keys [$];
        logic signed [KEY_W-1:0] k;
        logic [OP_W-1:0]         op;
        longint                  cur;
        int unsigned             step_max;
        int                      seg_len;
        int                      seg_base;
        int                      n_queries;
        int                      pick;
        int                      sel;
        int                      d;
        int                      lo;
        int                      hi;
        int                      alt_lo;
        int                      alt_hi;

        i_rst_n = 1'b0;
        start = 1'b0;
        i_op = OP_LOAD;
        i_entry_index = '0;
        i_key = '0;
        i_range_low = '0;
        i_range_high = '0;
        row_fixed = 1'b0;
        row_answer = '0;
        mismatch_count = 0;
        items_sent = 0;
        burst_left = 0;
        idle_cycles = 0;

        // Entries 0..7 hold an ascending run with a duplicate zero and both key extremes.
        directed_rows = '{
            '{OP_LOAD,   10'd0,    32'h8000_0000, 11'd0,    11'd2047, 1'b1, 1'b0, 11'd0},
            '{OP_LOAD,   10'd1,    -32'sd1000,    11'd2047, 11'd0,    1'b1, 1'b0, 11'd0},
            '{OP_LOAD,   10'd2,    -32'sd5,       11'd0,    11'd0,    1'b1, 1'b0, 11'd0},
            '{OP_LOAD,   10'd3,    32'd0,         11'd0,    11'd0,    1'b1, 1'b0, 11'd0},
            '{OP_LOAD,   10'd4,    32'd0,         11'd0,    11'd0,    1'b1, 1'b0, 11'd0},
            '{OP_LOAD,   10'd5,    32'd7,         11'd0,    11'd0,    1'b1, 1'b0, 11'd0},
            '{OP_LOAD,   10'd6,    32'd100000,    11'd0,    11'd0,    1'b1, 1'b0, 11'd0},
            '{OP_LOAD,   10'd7,    32'h7FFF_FFFF, 11'd0,    11'd0,    1'b1, 1'b0, 11'd0},
            '{OP_LOAD,   10'd1022, 32'd0,         11'd0,    11'd0,    1'b1, 1'b0, 11'd0},
            '{OP_LOAD,   10'd1023, 32'h7FFF_FFFF, 11'd0,    11'd0,    1'b1, 1'b0, 11'd0},
            '{OP_EXACT,  10'd0,    32'h8000_0000, 11'd0,    11'd8,    1'b1, 1'b1, 11'd0},
            '{OP_EXACT,  10'd0,    32'h7FFF_FFFF, 11'd0,    11'd8,    1'b1, 1'b1, 11'd7},
            '{OP_EXACT,  10'd0,    32'd0,         11'd0,    11'd8,    1'b0, 1'b0, 11'd0},
            '{OP_EXACT,  10'd0,    32'd3,         11'd0,    11'd8,    1'b1, 1'b0, 11'd0},
            '{OP_LOWER,  10'd0,    32'h8000_0000, 11'd0,    11'd8,    1'b1, 1'b0, 11'd0},
            '{OP_LOWER,  10'd0,    32'd0,         11'd0,    11'd8,    1'b0, 1'b0, 11'd0},
            '{OP_LOWER,  10'd0,    32'd1,         11'd0,    11'd8,    1'b0, 1'b0, 11'd0},
            '{OP_LOWER,  10'd0,    32'd0,         11'd0,    11'd3,    1'b0, 1'b0, 11'd0},
            '{OP_EXACT,  10'd0,    32'd0,         11'd5,    11'd5,    1'b1, 1'b0, 11'd0},
            '{OP_LOWER,  10'd0,    32'd0,         11'd6,    11'd2,    1'b1, 1'b0, 11'd6},
            '{OP_LOWER,  10'd0,    32'd5,         11'd2047, 11'd2047, 1'b1, 1'b0, 11'd1024},
            '{OP_EXACT,  10'd0,    32'hFFFF_FFFF, 11'd1500, 11'd2047, 1'b1, 1'b0, 11'd0},
            '{OP_LOWER,  10'd0,    32'd5,         11'd1022, 11'd2047, 1'b0, 1'b0, 11'd0},
            '{OP_EXACT,  10'd0,    32'h7FFF_FFFF, 11'd1023, 11'd1500, 1'b0, 1'b0, 11'd0},
            '{OP_UNUSED, 10'd1023, 32'hFFFF_FFFF, 11'd2047, 11'd2047, 1'b1, 1'b0, 11'd0}
        };

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (directed_rows[r]) begin
            send_item(directed_rows[r].op, directed_rows[r].idx, directed_rows[r].key,
                      directed_rows[r].lo, directed_rows[r].hi, directed_rows[r].fixed,
                      '{found: directed_rows[r].found, position: directed_rows[r].position});
        end
        wait_for_results();

        // Each pass loads a sorted segment and then searches mostly inside it.
        while (items_sent < ITEM_TARGET) begin
            seg_len = ($urandom_range(0, 9) == 0) ? $urandom_range(64, 256)
                                                  : $urandom_range(1, 40);
            if (seg_len > ITEM_TARGET - items_sent) begin
                seg_len = ITEM_TARGET - items_sent;
            end
            seg_base = ($urandom_range(0, 4) == 0) ? DEPTH - seg_len
                                                   : $urandom_range(0, DEPTH - seg_len);
            cur = ($urandom_range(0, 7) == 0) ? -64'sd2147483648
                                              : longint'($signed($urandom));
            step_max = ($urandom_range(0, 1) == 0) ? 3 : 32'hFFFF_FFFF / seg_len;
            if (step_max > 3 && $urandom_range(0, 1) == 0) begin
                cur = -64'sd2147483648 + $urandom_range(0, 1 << 20);
            end
            seg_keys.delete();
            for (int n = 0; n < seg_len; n++) begin
                k = (cur > 64'sd2147483647) ? 32'sh7FFF_FFFF : cur[KEY_W-1:0];
                seg_keys.push_back(k);
                send_item(OP_LOAD, IDX_W'(seg_base + n), k, BOUND_W'($urandom),
                          BOUND_W'($urandom), 1'b0, '0);
                cur += $urandom_range(0, step_max);
            end

            n_queries = $urandom_range(seg_len + 4, 2 * seg_len + 8);
            repeat (n_queries) begin
                if (items_sent >= ITEM_TARGET) begin
                    break;
                end
                pick = $urandom_range(0, 19);
                if (pick == 0) begin
                    // A stray load anywhere, which may leave the table out of order.
                    send_item(OP_LOAD, IDX_W'($urandom), $urandom, BOUND_W'($urandom),
                              BOUND_W'($urandom), 1'b0, '0);
                end else begin
                    op = (pick == 1) ? OP_UNUSED : ((pick % 2 == 1) ? OP_EXACT : OP_LOWER);
                    if ($urandom_range(0, 5) == 0) begin
                        k = $urandom;
                    end else begin
                        d = $urandom_range(0, 3);
                        k = seg_keys[$urandom_range(0, seg_len - 1)];
                        if (d == 0) begin
                            k = k - 1;
                        end else if (d == 3) begin
                            k = k + 1;
                        end
                    end
                    lo = seg_base + $urandom_range(0, seg_len);
                    hi = lo + $urandom_range(0, seg_base + seg_len - lo);
                    sel = $urandom_range(0, 11);
                    if (sel < 4) begin
                        lo = seg_base;
                        hi = seg_base + seg_len;
                    end else if (sel == 4) begin
                        lo = $urandom_range(0, 2047);
                        hi = $urandom_range(0, lo);
                    end else if (sel == 5) begin
                        alt_lo = $urandom_range(0, 2047);
                        alt_hi = $urandom_range(0, 2047);
                        if (range_loaded(alt_lo, alt_hi)) begin
                            lo = alt_lo;
                            hi = alt_hi;
                        end
                    end
                    if (hi == DEPTH && $urandom_range(0, 1) == 1) begin
                        hi = $urandom_range(DEPTH, 2047);
                    end
                    if (lo == DEPTH && $urandom_range(0, 1) == 1) begin
                        lo = $urandom_range(DEPTH, 2047);
                    end
                    send_item(op, IDX_W'($urandom), k, BOUND_W'(lo), BOUND_W'(hi), 1'b0, '0);
                end
            end
            if ($urandom_range(0, 3) == 0) begin
                wait_for_results();
            end
        end

        wait_for_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// File: sorted_table_search_core.f
sv/sts_pkg.sv
sv/sts_ctrl.sv
sv/sts_datapath.sv
sv/sorted_table_search_core.sv
tb/sv/tb.sv
